[hdl/ctr_spn16_stream_cipher_core_macros.svh]
// Assertion macros used by the cipher core port checker.
`ifndef CTR_SPN16_STREAM_CIPHER_CORE_MACROS_SVH
`define CTR_SPN16_STREAM_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CS16_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("cs16 check failed");

// Next-cycle implication, disabled while reset is held.
`define CS16_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("cs16 check failed");

`endif

[hdl/cs16_pkg.sv]
// Shared types, constants and helper functions for the SPN16 counter-mode cipher.
package cs16_pkg;

  localparam int BYTE_W     = 8;
  localparam int SBOX_DEPTH = 256;
  localparam int SBOX_AW    = $clog2(SBOX_DEPTH);
  localparam int KEY_W      = 16;
  localparam int CNT_W      = 2;
  localparam int CFG_IDX_W  = 1;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [SBOX_AW-1:0] sbox_addr_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_HIGH = 1'd1;

  // input action codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ENCRYPT = 1'b1;

  // key schedule round constants
  localparam byte_t RC1 = 8'h80;
  localparam byte_t RC2 = 8'h30;

  // out bit i takes in bit PERM[i]
  localparam logic [2:0] PERM [BYTE_W] = '{3'd5, 3'd1, 3'd3, 3'd0, 3'd6, 3'd2, 3'd7, 3'd4};

  // S-box write port, fanned out to every copy
  typedef struct packed {
    logic       en;
    sbox_addr_t addr;
    byte_t      data;
  } sbox_wr_t;

  function automatic byte_t permute_bits(input byte_t b);
    byte_t r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = b[PERM[i]];
    end
    return r;
  endfunction

  function automatic byte_t nib_swap(input byte_t b);
    return {b[3:0], b[7:4]};
  endfunction

endpackage

[hdl/cs16_sbox_ram.sv]
// One copy of the 256 x 8 S-box: one write port, two registered read ports.
module cs16_sbox_ram (
  input  logic                 clk,
  input  cs16_pkg::sbox_wr_t   wr,
  input  logic                 rd_en_a,
  input  cs16_pkg::sbox_addr_t rd_addr_a,
  output cs16_pkg::byte_t      rd_data_a,
  input  logic                 rd_en_b,
  input  cs16_pkg::sbox_addr_t rd_addr_b,
  output cs16_pkg::byte_t      rd_data_b
);
  import cs16_pkg::*;

  byte_t mem [SBOX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read-before-write when a read and a write share an edge
  always_ff @(posedge clk) begin
    if (rd_en_a) begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[hdl/ctr_spn16_stream_cipher_core.sv]
// Top level of the SPN16 counter-mode stream cipher core.
//
// Input channel (in_valid / in_stall): each beat either loads one S-box
// entry (in_action = load) or encrypts one or two plaintext bytes
// (in_action = encrypt). A load beat produces no result; an encrypt beat
// produces exactly one result beat on the out_ channel.
// Config port: cfg_wr_en writes cfg_wdata to register cfg_index
// (0 = cipher key, 1 = counter high byte). Write only while idle.
// An encrypt beat passes three S-box read stages on its way to out_valid:
// round 1 with the first key lookup, round 2 with the second key lookup,
// round 3. Throughput: one encrypt beat per cycle while out_stall is low,
// set by the three-stage read pipeline over four S-box copies.
// A load beat is held off (in_stall) while an encrypt beat sits in the
// first or second stage, so in-flight beats see the table as it was when
// they were accepted; a load right after encrypts waits until both of
// those stages are empty, and out_stall can keep them full for longer.
// Reset (rst_n low, synchronous) clears the pipeline, the low counter
// byte, the key and the counter high byte; S-box contents are untouched.
// When out_stall holds a result, stages drain forward into free slots and
// the input keeps taking beats until the pipeline is full.
module ctr_spn16_stream_cipher_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [cs16_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cs16_pkg::KEY_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  cs16_pkg::byte_t                     in_table_index,
  input  cs16_pkg::byte_t                     in_table_value,
  input  logic                                in_restart,
  input  cs16_pkg::byte_t                     in_plain_hi,
  input  cs16_pkg::byte_t                     in_plain_lo,
  input  logic [cs16_pkg::CNT_W-1:0]          in_byte_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cs16_pkg::byte_t                     out_cipher_hi,
  output cs16_pkg::byte_t                     out_cipher_lo,
  output logic [cs16_pkg::CNT_W-1:0]          out_valid_bytes
);
  import cs16_pkg::*;

  // config and counter state
  logic [KEY_W-1:0] cipher_key_r;
  byte_t            counter_high_r;
  byte_t            counter_low_r, counter_low_nxt;
  byte_t            ctr_use;
  byte_t            key_hi, key_lo;

  // stage valids
  logic s1_v_r, s2_v_r, s3_v_r;

  // stage payloads
  byte_t s1_plain_hi_r, s1_plain_lo_r;
  logic  s1_one_r;
  byte_t s2_plain_hi_r, s2_plain_lo_r;
  logic  s2_one_r;
  byte_t s2_w2_r, s2_w3_r;
  byte_t s3_plain_hi_r, s3_plain_lo_r;
  logic  s3_one_r;

  // registered S-box reads
  byte_t s1_sb_hi, s1_sb_lo, s1_sb_k;
  byte_t s2_sb_hi, s2_sb_lo, s2_sb_k;
  byte_t s3_sb_hi, s3_sb_lo;

  // handshake and flow
  logic is_enc, enc_take, load_take;
  logic out_free, s2_free, s1_free, s2_move, s1_move;

  // round datapath
  logic [KEY_W-1:0] blk0;
  byte_t w2, w3, w4, w5;
  byte_t a1_hi, a1_lo, a2_hi, a2_lo;
  byte_t ks_hi, ks_lo;

  sbox_wr_t sb_wr;

  assign key_hi = cipher_key_r[KEY_W-1 -: BYTE_W];
  assign key_lo = cipher_key_r[BYTE_W-1:0];

  // stages move forward into any free slot
  assign out_free = !s3_v_r || !out_stall;
  assign s2_free  = !s2_v_r || out_free;
  assign s2_move  = s2_v_r && out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign s1_move  = s1_v_r && s2_free;

  assign is_enc    = (in_action == ACT_ENCRYPT);
  assign in_stall  = is_enc ? !s1_free : (s1_v_r || s2_v_r);
  assign enc_take  = in_valid && !in_stall && is_enc;
  assign load_take = in_valid && !in_stall && !is_enc;

  assign sb_wr.en   = load_take;
  assign sb_wr.addr = in_table_index;
  assign sb_wr.data = in_table_value;

  // stage 0: counter block xor round key 0, first key lookup
  assign ctr_use         = in_restart ? '0 : counter_low_r;
  assign counter_low_nxt = ctr_use + 8'd1;
  assign blk0            = {counter_high_r, ctr_use} ^ cipher_key_r;

  // stage 1: round key 1, round 2 addresses
  assign w2    = key_hi ^ RC1 ^ s1_sb_k;
  assign w3    = w2 ^ key_lo;
  assign a1_hi = permute_bits(s1_sb_hi) ^ w2;
  assign a1_lo = permute_bits(s1_sb_lo) ^ w3;

  // stage 2: round key 2, round 3 addresses
  assign w4    = s2_w2_r ^ RC2 ^ s2_sb_k;
  assign w5    = w4 ^ s2_w3_r;
  assign a2_hi = permute_bits(s2_sb_hi) ^ w4;
  assign a2_lo = permute_bits(s2_sb_lo) ^ w5;

  // stage 3: keystream out of round 3
  assign ks_hi = permute_bits(s3_sb_hi);
  assign ks_lo = permute_bits(s3_sb_lo);

  cs16_sbox_ram u_ram_r1 (
    .clk       (clk),
    .wr        (sb_wr),
    .rd_en_a   (enc_take),
    .rd_addr_a (blk0[KEY_W-1 -: BYTE_W]),
    .rd_data_a (s1_sb_hi),
    .rd_en_b   (enc_take),
    .rd_addr_b (blk0[BYTE_W-1:0]),
    .rd_data_b (s1_sb_lo)
  );

  // key schedule copy: port a for the first lookup, port b for the second
  cs16_sbox_ram u_ram_key (
    .clk       (clk),
    .wr        (sb_wr),
    .rd_en_a   (enc_take),
    .rd_addr_a (nib_swap(key_lo)),
    .rd_data_a (s1_sb_k),
    .rd_en_b   (s1_move),
    .rd_addr_b (nib_swap(w3)),
    .rd_data_b (s2_sb_k)
  );

  cs16_sbox_ram u_ram_r2 (
    .clk       (clk),
    .wr        (sb_wr),
    .rd_en_a   (s1_move),
    .rd_addr_a (a1_hi),
    .rd_data_a (s2_sb_hi),
    .rd_en_b   (s1_move),
    .rd_addr_b (a1_lo),
    .rd_data_b (s2_sb_lo)
  );

  cs16_sbox_ram u_ram_r3 (
    .clk       (clk),
    .wr        (sb_wr),
    .rd_en_a   (s2_move),
    .rd_addr_a (a2_hi),
    .rd_data_a (s3_sb_hi),
    .rd_en_b   (s2_move),
    .rd_addr_b (a2_lo),
    .rd_data_b (s3_sb_lo)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r   <= '0;
      counter_high_r <= '0;
      counter_low_r  <= '0;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      s3_v_r         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CIPHER_KEY:   cipher_key_r   <= cfg_wdata;
          REG_COUNTER_HIGH: counter_high_r <= cfg_wdata[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (enc_take) begin
        counter_low_r <= counter_low_nxt;
      end
      if (s1_free) begin
        s1_v_r <= enc_take;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (enc_take) begin
      s1_plain_hi_r <= in_plain_hi;
      s1_plain_lo_r <= in_plain_lo;
      s1_one_r      <= (in_byte_count == CNT_W'(1));
    end
    if (s1_move) begin
      s2_plain_hi_r <= s1_plain_hi_r;
      s2_plain_lo_r <= s1_plain_lo_r;
      s2_one_r      <= s1_one_r;
      s2_w2_r       <= w2;
      s2_w3_r       <= w3;
    end
    if (s2_move) begin
      s3_plain_hi_r <= s2_plain_hi_r;
      s3_plain_lo_r <= s2_plain_lo_r;
      s3_one_r      <= s2_one_r;
    end
  end

  assign out_valid       = s3_v_r;
  assign out_cipher_hi   = s3_plain_hi_r ^ ks_hi;
  assign out_cipher_lo   = s3_one_r ? '0 : (s3_plain_lo_r ^ ks_lo);
  assign out_valid_bytes = s3_one_r ? CNT_W'(1) : CNT_W'(2);

endmodule

[hdl/cs16_port_chk.sv]
// Port-level checker for the cipher core and its bind.
`include "ctr_spn16_stream_cipher_core_macros.svh"

module cs16_port_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input cs16_pkg::byte_t                out_cipher_hi,
  input cs16_pkg::byte_t                out_cipher_lo,
  input logic [cs16_pkg::CNT_W-1:0]     out_valid_bytes
);
  import cs16_pkg::*;

  // a stalled result beat stays
  `CS16_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // result beat carries a legal byte count
  `CS16_ASSERT_NOW(a_out_count, clk, rst_n, out_valid, out_valid_bytes == CNT_W'(1) || out_valid_bytes == CNT_W'(2))

  // odd final byte: second cipher byte is zero
  `CS16_ASSERT_NOW(a_odd_zero, clk, rst_n, out_valid && out_valid_bytes == CNT_W'(1), out_cipher_lo == '0)

  // stalled payload holds
  `CS16_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_cipher_hi) && $stable(out_cipher_lo) && $stable(out_valid_bytes))

endmodule

bind ctr_spn16_stream_cipher_core cs16_port_chk u_port_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_cipher_hi   (out_cipher_hi),
  .out_cipher_lo   (out_cipher_lo),
  .out_valid_bytes (out_valid_bytes)
);

[tb/tb_ctr_spn16_stream_cipher_core.sv]
// Self-checking testbench for the SPN16 counter-mode stream cipher core.
module tb_ctr_spn16_stream_cipher_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cs16_pkg::*;

  localparam int LIMIT_CYCLES = 400_000;
  localparam int DRAIN_CYCLES = 8;        // pipeline is 3 deep
  localparam int PHASE_BEATS  = 255;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    byte_t            hi;
    byte_t            lo;
    logic [CNT_W-1:0] nbytes;
  } cipher_beat_t;

  // Tracks S-box contents, counter and registers, and queues the
  // ciphertext beats that the core owes us.
  class ciphertext_tracker;
    byte_t            sbox [SBOX_DEPTH];
    byte_t            ctr_low;
    logic [KEY_W-1:0] key;
    byte_t            nonce;
    cipher_beat_t     owed [$];
    int               errors;

    function new();
      ctr_low = '0;
      key     = '0;
      nonce   = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
      if (idx == REG_CIPHER_KEY) begin
        key = data;
      end else if (idx == REG_COUNTER_HIGH) begin
        nonce = data[BYTE_W-1:0];
      end
    endfunction

    // out bit i <- in bit {5,1,3,0,6,2,7,4}[i], written out by hand
    function byte_t shuffle(byte_t b);
      return {b[4], b[7], b[2], b[6], b[0], b[3], b[1], b[5]};
    endfunction

    function logic [15:0] spn_keystream(logic [15:0] blk);
      byte_t       w0, w1, w2, w3, w4, w5;
      logic [15:0] rk [3];
      logic [15:0] st;
      w0 = key[15:8];
      w1 = key[7:0];
      w2 = w0 ^ RC1 ^ sbox[{w1[3:0], w1[7:4]}];
      w3 = w2 ^ w1;
      w4 = w2 ^ RC2 ^ sbox[{w3[3:0], w3[7:4]}];
      w5 = w4 ^ w3;
      rk[0] = key;
      rk[1] = {w2, w3};
      rk[2] = {w4, w5};
      st = blk;
      for (int r = 0; r < 3; r++) begin
        st = st ^ rk[r];
        st = {shuffle(sbox[st[15:8]]), shuffle(sbox[st[7:0]])};
      end
      return st;
    endfunction

    function void note_beat(logic act, byte_t idx, byte_t val, logic restart,
                            byte_t phi, byte_t plo, logic [CNT_W-1:0] cnt);
      logic [15:0]  ks;
      cipher_beat_t want;
      if (act == ACT_LOAD) begin
        sbox[idx] = val;
        return;
      end
      if (restart) ctr_low = '0;
      ks = spn_keystream({nonce, ctr_low});
      want.hi = phi ^ ks[15:8];
      if (cnt == 2'd1) begin
        want.lo     = '0;
        want.nbytes = 2'd1;
      end else begin
        // 0 and 3 behave like a full pair
        want.lo     = plo ^ ks[7:0];
        want.nbytes = 2'd2;
      end
      owed.push_back(want);
      ctr_low = ctr_low + 8'd1;
    endfunction

    function void check_beat(byte_t hi, byte_t lo, logic [CNT_W-1:0] nbytes);
      cipher_beat_t want;
      if (owed.size() == 0) begin
        $error("unexpected result beat: cipher_hi=%02h cipher_lo=%02h valid_bytes=%0d",
               hi, lo, nbytes);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (hi !== want.hi) begin
        $error("cipher_hi mismatch: expected %02h, got %02h", want.hi, hi);
        errors++;
      end
      if (lo !== want.lo) begin
        $error("cipher_lo mismatch: expected %02h, got %02h", want.lo, lo);
        errors++;
      end
      if (nbytes !== want.nbytes) begin
        $error("valid_bytes mismatch: expected %0d, got %0d", want.nbytes, nbytes);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_action;
  byte_t                in_table_index;
  byte_t                in_table_value;
  logic                 in_restart;
  byte_t                in_plain_hi;
  byte_t                in_plain_lo;
  logic [CNT_W-1:0]     in_byte_count;
  logic                 out_valid;
  logic                 out_stall;
  byte_t                out_cipher_hi;
  byte_t                out_cipher_lo;
  logic [CNT_W-1:0]     out_valid_bytes;

  ciphertext_tracker tracker;
  int                in_gap_max;   // per-beat idle draw on the input side
  int                out_gap_max;  // per-beat stall draw on the result side

  ctr_spn16_stream_cipher_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .in_restart      (in_restart),
    .in_plain_hi     (in_plain_hi),
    .in_plain_lo     (in_plain_lo),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_hi   (out_cipher_hi),
    .out_cipher_lo   (out_cipher_lo),
    .out_valid_bytes (out_valid_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One input beat. Optional idle gap first; valid is only dropped when a
  // gap is drawn, so back-to-back beats keep it high. Payload is held until
  // the edge where stall is low, then the beat is handed to the tracker.
  task automatic send_beat(logic act, byte_t idx, byte_t val, logic restart,
                           byte_t phi, byte_t plo, logic [CNT_W-1:0] cnt);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_table_index <= idx;
    in_table_value <= val;
    in_restart     <= restart;
    in_plain_hi    <= phi;
    in_plain_lo    <= plo;
    in_byte_count  <= cnt;
    do @(posedge clk); while (in_stall);
    tracker.note_beat(act, idx, val, restart, phi, plo, cnt);
  endtask

  // Mostly encrypts; loads rewrite already-filled entries. Fields a beat
  // does not use still get random noise.
  task automatic send_random(bit restart_ok);
    byte_t            idx, val, phi, plo;
    logic             restart;
    logic [CNT_W-1:0] cnt;
    int               pick;
    idx  = BYTE_W'($urandom);
    val  = BYTE_W'($urandom);
    phi  = BYTE_W'($urandom);
    plo  = BYTE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_beat(ACT_LOAD, idx, val, 1'($urandom_range(0, 1)), phi, plo,
                CNT_W'($urandom_range(0, 3)));
    end else begin
      restart = restart_ok && ($urandom_range(0, 39) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 6)       cnt = 2'd2;
      else if (pick < 8)  cnt = 2'd1;
      else if (pick == 8) cnt = 2'd0;
      else                cnt = 2'd3;
      send_beat(ACT_ENCRYPT, idx, val, restart, phi, plo, cnt);
    end
  endtask

  // Wait until every owed result is back, then let in-flight loads settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; the nonce word carries junk in its upper
  // byte that the core must drop.
  task automatic program_regs(logic [KEY_W-1:0] key, byte_t nonce);
    byte_t            junk;
    logic [KEY_W-1:0] nonce_word;
    junk       = BYTE_W'($urandom);
    nonce_word = {junk, nonce};
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CIPHER_KEY;
    cfg_wdata <= key;
    @(posedge clk);
    tracker.write_reg(REG_CIPHER_KEY, key);
    cfg_index <= REG_COUNTER_HIGH;
    cfg_wdata <= nonce_word;
    @(posedge clk);
    tracker.write_reg(REG_COUNTER_HIGH, nonce_word);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: stall for a drawn number of cycles per beat, then take
  // the next beat and check it.
  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = $urandom_range(0, out_gap_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_beat(out_cipher_hi, out_cipher_lo, out_valid_bytes);
    end
  end

  // Hang guard.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key;
    byte_t            nonce;
    tracker     = new();
    in_gap_max  = 0;
    out_gap_max = 0;

    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= REG_CIPHER_KEY;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_action      <= ACT_LOAD;
    in_table_index <= '0;
    in_table_value <= '0;
    in_restart     <= 1'b0;
    in_plain_hi    <= '0;
    in_plain_lo    <= '0;
    in_byte_count  <= 2'd2;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, written explicitly so both registers see a write.
    program_regs(16'h0000, 8'h00);

    // Fill the whole S-box before any encrypt can read it.
    in_gap_max = 3;
    for (int i = 0; i < SBOX_DEPTH; i++) begin
      send_beat(ACT_LOAD, byte_t'(i), byte_t'($urandom), 1'b0, 8'h00, 8'h00, 2'd2);
    end

    // Directed: plaintext extremes, odd final byte, out-of-range counts,
    // restart, loads right behind encrypts (load hold-off), back to back.
    in_gap_max = 0;
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 2'd2);
    send_beat(ACT_ENCRYPT, 8'hFF, 8'hFF, 1'b0, 8'hFF, 8'hFF, 2'd2);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'hFF, 8'hFF, 2'd1);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 2'd1);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'hA5, 8'h5A, 2'd0);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'h5A, 8'hA5, 2'd3);
    send_beat(ACT_LOAD,    8'h00, 8'hFF, 1'b1, 8'hFF, 8'hFF, 2'd1);
    send_beat(ACT_LOAD,    8'hFF, 8'h00, 1'b1, 8'h00, 8'h00, 2'd3);
    send_beat(ACT_ENCRYPT, 8'h12, 8'h34, 1'b0, 8'h3C, 8'hC3, 2'd2);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b1, 8'h12, 8'h34, 2'd2);
    send_beat(ACT_LOAD,    8'h80, 8'h7F, 1'b0, 8'h00, 8'h00, 2'd2);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'hC3, 8'h3C, 2'd2);
    out_gap_max = 14;  // let results back up behind a stalled sink
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'h01, 8'h80, 2'd2);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'h80, 8'h01, 2'd1);
    send_beat(ACT_LOAD,    8'h7F, 8'h80, 1'b0, 8'h00, 8'h00, 2'd2);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'hFF, 8'h00, 2'd2);
    drain();

    // Key and nonce at their all-ones extremes.
    program_regs(16'hFFFF, 8'hFF);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 2'd2);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'hFF, 8'h00, 2'd1);
    send_beat(ACT_ENCRYPT, 8'h00, 8'h00, 1'b0, 8'h55, 8'hAA, 2'd2);
    drain();

    // Random phases. Odd phases never restart, so the low counter byte
    // keeps counting and can run past 255 and wrap. Every phase ends with a
    // full drain before the registers change.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      key   = KEY_W'($urandom);
      nonce = BYTE_W'($urandom);
      case (ph)
        0: begin
          in_gap_max  = 14;
          out_gap_max = 14;
        end
        1: begin  // no idling on either side
          key         = 16'h0000;
          nonce       = 8'h00;
          in_gap_max  = 0;
          out_gap_max = 0;
        end
        2: begin  // full-rate input into a slow sink
          key         = 16'hFFFF;
          nonce       = 8'hFF;
          in_gap_max  = 0;
          out_gap_max = 14;
        end
        3: begin
          in_gap_max  = 14;
          out_gap_max = 0;
        end
        4: begin
          key         = 16'h00FF;
          nonce       = 8'h80;
          in_gap_max  = 14;
          out_gap_max = 14;
        end
        default: begin
          in_gap_max  = 3;
          out_gap_max = 3;
        end
      endcase
      program_regs(key, nonce);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_random(ph % 2 == 0);
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/cs16_pkg.sv
hdl/cs16_sbox_ram.sv
hdl/ctr_spn16_stream_cipher_core.sv
hdl/cs16_port_chk.sv
tb/tb_ctr_spn16_stream_cipher_core.sv
